@@ rtl/lfdt_pkg.sv @@
// Shared types and constants for the lowest-free descriptor table.
// Used by lfdt_ctrl, lfdt_datapath, the top level and the checker.
package lfdt_pkg;

    // Command codes carried in the input item
    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    // Status codes carried in the result item
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_HANDLE  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_BAD_FD     = 2'd3;

    // Field widths and stream widths
    localparam int CMD_W       = 2;
    localparam int SLOT_W      = 16;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    // Bitmap memory word: one used bit per slot
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FETCH,
        S_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
        logic scan_step;
        logic fetch;
        logic out_from_exec;
        logic out_from_reg;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic create_ok;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/lfdt_ctrl.sv @@
// Controller state machine for the descriptor table.
// Depends on lfdt_pkg; drives lfdt_datapath through dp_cmd_t.
module lfdt_ctrl
    import lfdt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.create_ok) begin
                    state_next = S_SCAN;
                end else if (stat.out_free) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_SCAN: begin
                if (!stat.scan_done) begin
                    state_next = S_FETCH;
                end else if (stat.out_free) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_FETCH: begin
                state_next = S_SCAN;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
            end
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_EXEC: begin
                cmd.exec          = 1'b1;
                cmd.out_from_exec = !stat.create_ok && stat.out_free;
            end
            S_SCAN: begin
                cmd.scan_step    = 1'b1;
                cmd.out_from_reg = stat.scan_done && stat.out_free;
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
            end
            S_RESP: begin
                cmd.out_from_reg = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/lfdt_datapath.sv @@
// Datapath: bitmap and handle memories, item registers, free-slot search
// and the result register. Depends on lfdt_pkg; commanded by lfdt_ctrl.
module lfdt_datapath
    import lfdt_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LF_W    = IDX_W + 1;
    localparam int WORDS   = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CAND_W  = WADDR_W + BIT_W;

    // Unpack the input item
    logic [CMD_W-1:0]    in_cmd;
    logic [SLOT_W-1:0]   in_idx;
    logic [HANDLE_W-1:0] in_hdl;
    logic                in_range;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_idx   = s_tdata[CMD_W+SLOT_W-1:CMD_W];
    assign in_hdl   = s_tdata[CMD_W+SLOT_W+HANDLE_W-1:CMD_W+SLOT_W];
    assign in_range = 32'(in_idx) < ENTRIES;

    // Item registers
    logic [CMD_W-1:0]    cmd_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [HANDLE_W-1:0] hdl_reg;
    logic                in_range_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg      <= in_cmd;
            idx_reg      <= in_idx;
            hdl_reg      <= in_hdl;
            in_range_reg <= in_range;
        end
    end

    // Lowest free slot, ENTRIES when the table is full
    logic [LF_W-1:0]    lf_reg;
    logic [LF_W-1:0]    lf_next;
    logic               full;
    logic [WADDR_W-1:0] lf_word;
    logic [BIT_W-1:0]   lf_bit;

    assign full    = lf_reg == LF_W'(ENTRIES);
    assign lf_word = WADDR_W'(lf_reg >> BIT_W);
    assign lf_bit  = BIT_W'(lf_reg);

    // Memories
    logic [WORD_BITS-1:0] bitmap_mem [WORDS];
    logic [HANDLE_W-1:0]  handle_mem [ENTRIES];

    logic                 bm_rd_en;
    logic [WADDR_W-1:0]   bm_rd_addr;
    logic [WORD_BITS-1:0] bm_q_reg;
    logic                 bm_wr_en;
    logic [WADDR_W-1:0]   bm_wr_addr;
    logic [WORD_BITS-1:0] bm_wr_data;
    logic [IDX_W-1:0]     hm_rd_addr;
    logic [HANDLE_W-1:0]  hm_q_reg;
    logic                 hm_wr_en;

    // Clearing pass counter
    logic [WADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_cnt_reg <= clr_cnt_reg + WADDR_W'(1);
        end
    end

    // Search registers
    logic [WADDR_W-1:0]   scan_word_reg;
    logic [WORD_BITS-1:0] scan_data_reg;

    // Decode the looked-up slot
    logic [WADDR_W-1:0]   idx_word;
    logic [BIT_W-1:0]     idx_bit;
    logic                 slot_valid;
    logic                 create_ok;
    logic                 free_ok;
    logic [STATUS_W-1:0]  ex_status;
    logic [SLOT_W-1:0]    ex_slot;
    logic [HANDLE_W-1:0]  ex_handle;

    assign idx_word   = WADDR_W'(idx_reg >> BIT_W);
    assign idx_bit    = BIT_W'(idx_reg);
    assign slot_valid = in_range_reg && bm_q_reg[idx_bit];
    assign create_ok  = (cmd_reg == CMD_CREATE) && (hdl_reg != '0) && !full;
    assign free_ok    = (cmd_reg == CMD_FREE) && slot_valid;

    // Work out the result of the item
    always_comb begin
        ex_status = ST_BAD_FD;
        ex_slot   = '0;
        ex_handle = '0;
        case (cmd_reg)
            CMD_CREATE: begin
                if (hdl_reg == '0) begin
                    ex_status = ST_NO_HANDLE;
                end else if (full) begin
                    ex_status = ST_TABLE_FULL;
                end else begin
                    ex_status = ST_OK;
                    ex_slot   = SLOT_W'(lf_reg);
                end
            end
            CMD_LOOKUP: begin
                if (slot_valid) begin
                    ex_status = ST_OK;
                    ex_handle = hm_q_reg;
                end
            end
            CMD_FREE: begin
                if (slot_valid) begin
                    ex_status = ST_OK;
                end
            end
            default: begin
                ex_status = ST_BAD_FD;
            end
        endcase
    end

    // Find the lowest clear bit of the word under search
    logic                 free_found;
    logic [BIT_W-1:0]     free_pos;
    logic [CAND_W-1:0]    cand;
    logic                 cand_in;
    logic [LF_W-1:0]      lf_scan;
    logic                 scan_done;

    always_comb begin
        free_found = 1'b0;
        free_pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!scan_data_reg[i]) begin
                free_found = 1'b1;
                free_pos   = BIT_W'(i);
            end
        end
    end

    assign cand      = {scan_word_reg, free_pos};
    assign cand_in   = free_found && (32'(cand) < ENTRIES);
    assign lf_scan   = cand_in ? LF_W'(cand) : LF_W'(ENTRIES);
    assign scan_done = free_found || (scan_word_reg == WADDR_W'(WORDS - 1));

    // Memory port selection
    always_comb begin
        bm_rd_en   = 1'b0;
        bm_rd_addr = '0;
        hm_rd_addr = '0;
        bm_wr_en   = 1'b0;
        bm_wr_addr = '0;
        bm_wr_data = '0;
        hm_wr_en   = 1'b0;
        if (cmd.accept) begin
            bm_rd_en = 1'b1;
            if (in_cmd == CMD_CREATE) begin
                bm_rd_addr = full ? '0 : lf_word;
                hm_rd_addr = IDX_W'(lf_reg);
            end else begin
                bm_rd_addr = in_range ? WADDR_W'(in_idx >> BIT_W) : '0;
                hm_rd_addr = IDX_W'(in_idx);
            end
        end else if (cmd.scan_step && !scan_done) begin
            bm_rd_en   = 1'b1;
            bm_rd_addr = scan_word_reg + WADDR_W'(1);
        end
        if (cmd.clear_en) begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = clr_cnt_reg;
        end else if (cmd.exec && create_ok) begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = lf_word;
            bm_wr_data = bm_q_reg | (WORD_BITS'(1) << lf_bit);
            hm_wr_en   = 1'b1;
        end else if (cmd.exec && free_ok) begin
            bm_wr_en   = 1'b1;
            bm_wr_addr = idx_word;
            bm_wr_data = bm_q_reg & ~(WORD_BITS'(1) << idx_bit);
        end
    end

    // Bitmap memory
    always_ff @(posedge aclk) begin
        if (bm_wr_en) begin
            bitmap_mem[bm_wr_addr] <= bm_wr_data;
        end
        if (bm_rd_en) begin
            bm_q_reg <= bitmap_mem[bm_rd_addr];
        end
    end

    // Handle memory
    always_ff @(posedge aclk) begin
        if (hm_wr_en) begin
            handle_mem[IDX_W'(lf_reg)] <= hdl_reg;
        end
        if (cmd.accept) begin
            hm_q_reg <= handle_mem[hm_rd_addr];
        end
    end

    // Lowest free slot tracking
    always_comb begin
        lf_next = lf_reg;
        if (cmd.exec && free_ok && (32'(idx_reg) < 32'(lf_reg))) begin
            lf_next = LF_W'(idx_reg);
        end else if (cmd.scan_step && scan_done) begin
            lf_next = lf_scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lf_reg <= '0;
        end else begin
            lf_reg <= lf_next;
        end
    end

    // Seed the search with the word just claimed, then step word by word
    always_ff @(posedge aclk) begin
        if (cmd.exec && create_ok) begin
            scan_word_reg <= lf_word;
            scan_data_reg <= bm_q_reg | (WORD_BITS'(1) << lf_bit);
        end else if (cmd.scan_step && !scan_done) begin
            scan_word_reg <= scan_word_reg + WADDR_W'(1);
        end else if (cmd.fetch) begin
            scan_data_reg <= bm_q_reg;
        end
    end

    // Hold the result until the output stage is free
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [HANDLE_W-1:0] res_handle_reg;

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= ex_status;
            res_slot_reg   <= ex_slot;
            res_handle_reg <= ex_handle;
        end
    end

    // Output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_from_exec || cmd.out_from_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_from_exec) begin
            m_tdata_reg <= OUT_TDATA_W'({ex_handle, ex_slot, ex_status});
        end else if (cmd.out_from_reg) begin
            m_tdata_reg <= OUT_TDATA_W'({res_handle_reg, res_slot_reg, res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.clear_last = clr_cnt_reg == WADDR_W'(WORDS - 1);
    assign stat.create_ok  = create_ok;
    assign stat.scan_done  = scan_done;
    assign stat.out_free   = out_free;

endmodule

@@ rtl/lowest_free_descriptor_table.sv @@
// Top level of the lowest-free descriptor table.
// Depends on lfdt_pkg, lfdt_ctrl and lfdt_datapath.
//
//  Channel  Dir  Handshake          tdata fields (lowest bit up)
//  s_       in   s_tvalid/s_tready  command[1:0] slot_index[17:2] handle_in[49:18]
//  m_       out  m_tvalid/m_tready  status[1:0] slot_out[17:2] handle_out[49:18]
//
// Lookup, free and failed create: one step for the memory read and one to
// decide and write back.
// A create that claims a slot then runs the word-at-a-time search of the
// bitmap memory for the next free slot.
// After reset a clearing pass empties the bitmap one word at a time;
// s_tready stays low meanwhile. A result waiting in the output register does
// not block the next transfer in; only the one after waits for m_tready.
module lowest_free_descriptor_table
    import lfdt_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command, slot_index, handle_in
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // status, slot_out, handle_out
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lfdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfdt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/lfdt_checker.sv @@
// Port-level checker for the descriptor table, bound to the top level.
// Depends on lfdt_pkg.
module lfdt_checker
    import lfdt_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // No result straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One transfer in at a time: the item is worked on before the next
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // Slot and handle are zero unless the status is ok
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |->
            (m_tdata[17:2] == '0) && (m_tdata[49:18] == '0))
        else $error("payload on a failed result");

endmodule

bind lowest_free_descriptor_table lfdt_checker u_lfdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/tb_top.sv @@
// Self-checking bench for the lowest-free descriptor table: directed rows, then random traffic.
// It runs its own model of the slot bitmap and handle store to predict each result.
// Depends on lfdt_pkg and lowest_free_descriptor_table.
module tb_top;
    import lfdt_pkg::*;

    localparam int ENTRIES       = 256;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_IDLE      = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_MAX    = 10;
    localparam int N_DIRECTED    = 24;

    // Command value with no meaning in the package; the block must reject it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } mix_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SLOT_W-1:0]   idx;
        logic [HANDLE_W-1:0] obj;
    } fd_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] obj;
    } fd_rsp_t;

    // One directed row; fixed marks rows whose result is typed in below
    typedef struct packed {
        fd_req_t req;
        logic    fixed;
        fd_rsp_t rsp;
    } fd_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // command, slot_index, handle_in
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // status, slot_out, handle_out

    // Shadow copy of the descriptor table
    bit                  slot_busy [ENTRIES];
    logic [HANDLE_W-1:0] slot_obj  [ENTRIES];
    int                  busy_count;

    fd_rsp_t pending_results [$];
    int      fail_count;
    int      cycle_count;
    int      rx_stall;
    bit      no_idle;
    bit      sender_hot;

    fd_row_t directed_rows [N_DIRECTED] = '{
        '{'{CMD_LOOKUP, 16'h0000, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_FREE,   16'h0000, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_CREATE, 16'h0000, 32'h0000_0000}, 1'b1, '{ST_NO_HANDLE, 16'd0, 32'h0}},
        '{'{CMD_CREATE, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_CREATE, 16'h0000, 32'h0000_0001}, 1'b1, '{ST_OK,        16'd1, 32'h0}},
        '{'{CMD_CREATE, 16'h1234, 32'hA5A5_5A5A}, 1'b1, '{ST_OK,        16'd2, 32'h0}},
        '{'{CMD_LOOKUP, 16'h0000, 32'h0000_0000}, 1'b1, '{ST_OK, 16'd0, 32'hFFFF_FFFF}},
        '{'{CMD_LOOKUP, 16'h0001, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 16'd0, 32'h0000_0001}},
        '{'{CMD_LOOKUP, 16'h0002, 32'h0000_0000}, 1'b0, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_LOOKUP, 16'h0003, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_LOOKUP, 16'h0100, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_LOOKUP, 16'hFFFF, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_FREE,   16'hFFFF, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_FREE,   16'h00FF, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_UNUSED, 16'h0000, 32'hFFFF_FFFF}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_UNUSED, 16'hFFFF, 32'h0000_0000}, 1'b0, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_FREE,   16'h0001, 32'h0000_0000}, 1'b1, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_LOOKUP, 16'h0001, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_FREE,   16'h0001, 32'h0000_0000}, 1'b1, '{ST_BAD_FD,    16'd0, 32'h0}},
        '{'{CMD_CREATE, 16'h0000, 32'h8000_0000}, 1'b1, '{ST_OK,        16'd1, 32'h0}},
        '{'{CMD_FREE,   16'h0000, 32'h0000_0000}, 1'b1, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_CREATE, 16'h0000, 32'h0000_FFFF}, 1'b1, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_LOOKUP, 16'h0000, 32'h0000_0000}, 1'b0, '{ST_OK,        16'd0, 32'h0}},
        '{'{CMD_CREATE, 16'h0000, 32'h0000_0000}, 1'b1, '{ST_NO_HANDLE, 16'd0, 32'h0}}
    };

    lowest_free_descriptor_table #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock: 12 units per period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_idle();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Apply one command to the shadow table and return the result it gives
    function automatic fd_rsp_t table_step(fd_req_t r);
        fd_rsp_t rsp;
        int      free_slot;
        rsp       = '{ST_OK, '0, '0};
        free_slot = -1;
        case (r.cmd)
            CMD_CREATE: begin
                if (r.obj == '0) begin
                    rsp.status = ST_NO_HANDLE;
                end else begin
                    for (int s = ENTRIES - 1; s >= 0; s--) begin
                        if (!slot_busy[s]) free_slot = s;
                    end
                    if (free_slot < 0) begin
                        rsp.status = ST_TABLE_FULL;
                    end else begin
                        slot_busy[free_slot] = 1'b1;
                        slot_obj[free_slot]  = r.obj;
                        busy_count++;
                        rsp.slot = SLOT_W'(free_slot);
                    end
                end
            end
            CMD_LOOKUP, CMD_FREE: begin
                if (r.idx >= ENTRIES || !slot_busy[r.idx]) begin
                    rsp.status = ST_BAD_FD;
                end else if (r.cmd == CMD_LOOKUP) begin
                    rsp.obj = slot_obj[r.idx];
                end else begin
                    slot_busy[r.idx] = 1'b0;
                    busy_count--;
                end
            end
            default: begin
                rsp.status = ST_BAD_FD;
            end
        endcase
        return rsp;
    endfunction

    // Pick an allocated slot from a random starting point, or any slot if none is held
    function automatic logic [SLOT_W-1:0] pick_busy();
        int start;
        start = $urandom_range(0, ENTRIES - 1);
        if (busy_count == 0) begin
            return SLOT_W'(start);
        end
        for (int k = 0; k < ENTRIES; k++) begin
            if (slot_busy[(start + k) % ENTRIES]) return SLOT_W'((start + k) % ENTRIES);
        end
        return SLOT_W'(start);
    endfunction

    function automatic fd_req_t make_item(mix_t mode);
        fd_req_t r;
        int      roll;
        bit      noise;
        r.cmd = CMD_CREATE;
        r.idx = SLOT_W'($urandom_range(0, 65535));
        r.obj = $urandom();
        if ($urandom_range(0, 29) == 0) r.obj = '0;
        roll  = $urandom_range(0, 99);
        noise = 1'b0;
        case (mode)
            MIX_FILL: begin
                if (roll >= 90) begin
                    r.cmd = CMD_LOOKUP;
                    r.idx = pick_busy();
                end
            end
            MIX_DRAIN: begin
                if (roll < 70) begin
                    r.cmd = CMD_FREE;
                    r.idx = pick_busy();
                end else if (roll < 85) begin
                    r.cmd = CMD_LOOKUP;
                    r.idx = pick_busy();
                end else begin
                    noise = 1'b1;
                end
            end
            default: begin
                if (roll < 40) begin
                    r.cmd = CMD_CREATE;
                end else if (roll < 65) begin
                    r.cmd = CMD_LOOKUP;
                    r.idx = pick_busy();
                end else if (roll < 85) begin
                    r.cmd = CMD_FREE;
                    r.idx = pick_busy();
                end else begin
                    noise = 1'b1;
                end
            end
        endcase
        // Noise: any command, any index, in range or well past it
        if (noise) begin
            r.cmd = CMD_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 0) r.idx = SLOT_W'($urandom_range(0, ENTRIES - 1));
        end
        return r;
    endfunction

    // Present one command; entered and left at a falling edge.
    // Valid stays high after the transfer until the next call or stop_sender.
    task automatic send_cmd(input fd_req_t r, input bit fixed, input fd_rsp_t fixed_rsp);
        int      gap;
        fd_rsp_t rsp;
        gap = draw_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {{(IN_TDATA_W - CMD_W - SLOT_W - HANDLE_W){1'b0}}, r.obj, r.idx, r.cmd};
        sender_hot = 1'b1;
        do @(posedge aclk); while (!s_tready);
        rsp = table_step(r);
        pending_results.push_back(fixed ? fixed_rsp : rsp);
        @(negedge aclk);
    endtask

    task automatic stop_sender();
        if (sender_hot) s_tvalid <= 1'b0;
        sender_hot = 1'b0;
    endtask

    // Hold the input until every outstanding result has come back
    task automatic drain_results();
        stop_sender();
        wait (pending_results.size() == 0);
        @(negedge aclk);
    endtask

    task automatic run_random(input mix_t mode, input int count);
        repeat (count) send_cmd(make_item(mode), 1'b0, '0);
    endtask

    // Receiver: after each result taken, stall for a random draw from draw_idle
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        fd_rsp_t want;
        fd_rsp_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[1:0], m_tdata[17:2], m_tdata[49:18]};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("[%0d] result with nothing outstanding: status %0d slot %0d handle %h",
                             cycle_count, got.status, got.slot, got.obj);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("[%0d] wanted status %0d slot %0d handle %h, got %0d %0d %h",
                                 cycle_count, want.status, want.slot, want.obj,
                                 got.status, got.slot, got.obj);
                end
            end
            rx_stall = draw_idle();
        end
    end

    initial begin
        int extra;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        rx_stall    = 0;
        no_idle     = 1'b0;
        sender_hot  = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        busy_count  = 0;
        for (int s = 0; s < ENTRIES; s++) begin
            slot_busy[s] = 1'b0;
            slot_obj[s]  = '0;
        end
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
        drain_results();

        // Fill the table, then push on past full
        while (busy_count < ENTRIES) send_cmd(make_item(MIX_FILL), 1'b0, '0);
        run_random(MIX_FILL, 20);
        drain_results();

        // Punch holes so that creates land in the middle
        run_random(MIX_DRAIN, 120);
        drain_results();

        // Mixed traffic, the first stretch back to back on both sides
        no_idle = 1'b1;
        run_random(MIX_ANY, 50);
        no_idle = 1'b0;
        run_random(MIX_ANY, 120);
        stop_sender();

        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        extra = pending_results.size();
        if (fail_count == 0 && extra == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lfdt_pkg.sv
rtl/lfdt_ctrl.sv
rtl/lfdt_datapath.sv
rtl/lowest_free_descriptor_table.sv
rtl/lfdt_checker.sv
dv/tb_top.sv
